FILE: rtl/core/mfs_pkg.sv
// Shared constants and types for the Manchester frame serializer.
package mfs_pkg;

	localparam int unsigned WORD_BITS_DEF  = 32;
	localparam int unsigned SYNC_SLOTS_DEF = 5;

	localparam int unsigned IN_WORD_W = 32;
	localparam int unsigned FRAME_W   = 16;

	localparam logic [FRAME_W-1:0] FRAMES_PER_SLOT_RST = 16'd40;

	// Sync slot k takes bit k: high, high, high, low, then high.
	localparam logic [15:0] SYNC_PATTERN = 16'h0017;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] value;
	} rem_result_t;

endpackage

FILE: rtl/core/manchester_frame_serializer.sv
// Top level of the Manchester frame serializer: handshakes, registers, core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  config   | wr_en                | wr_data (frames per slot)
//  input    | in_valid / in_stall  | next_word, last_frame
//  output   | out_valid / out_stall| line_level, word_taken, last_out
//
// One frame is accepted per cycle while in_stall is low. A result is offered on out_valid
// once its transaction has passed the input register and then the result register, and the
// two stages advance together, so output stalls only back up once both are full.
// A slot length write starts a bit-serial remainder of the frame count; in_stall is high
// in the write cycle and while the remainder runs. Reset clears all counters, the word
// and the stage valids and sets the slot length to 40 frames.
module manchester_frame_serializer #(
	parameter int unsigned WORD_BITS  = mfs_pkg::WORD_BITS_DEF,
	parameter int unsigned SYNC_SLOTS = mfs_pkg::SYNC_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mfs_pkg::FRAME_W-1:0]   wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mfs_pkg::IN_WORD_W-1:0] next_word,
	input  logic                          last_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          line_level,
	output logic                          word_taken,
	output logic                          last_out
);
	import mfs_pkg::*;

	logic [FRAME_W-1:0]   fps_q;
	logic                 valid_s1;
	logic [IN_WORD_W-1:0] word_s1;
	logic                 last_s1;
	logic                 valid_s2;
	logic                 level_s2;
	logic                 taken_s2;
	logic                 last_s2;

	logic                 advance;
	logic                 accept;
	logic                 rem_busy;
	rem_result_t          rem_res;
	logic [FRAME_W-1:0]   frame_count;
	logic                 level;
	logic                 taken;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = rem_busy || (valid_s1 && !advance);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q <= FRAMES_PER_SLOT_RST;
		end else if (wr_en) begin
			fps_q <= wr_data;
		end
	end

	mfs_residue u_residue (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (wr_en),
		.divisor  (wr_data),
		.dividend (frame_count),
		.busy     (rem_busy),
		.result   (rem_res)
	);

	mfs_core #(
		.WORD_BITS  (WORD_BITS),
		.SYNC_SLOTS (SYNC_SLOTS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.next_word       (word_s1),
		.frames_per_slot (fps_q),
		.residue         (rem_res),
		.frame_count     (frame_count),
		.level           (level),
		.taken           (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= next_word;
			last_s1 <= last_frame;
		end
		if (advance) begin
			level_s2 <= level;
			taken_s2 <= taken;
			last_s2  <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign line_level = level_s2;
	assign word_taken = taken_s2;
	assign last_out   = last_s2;

endmodule

FILE: rtl/core/mfs_residue.sv
// Bit-serial remainder of the frame count by a newly written slot length.
module mfs_residue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mfs_pkg::FRAME_W-1:0]  divisor,
	input  logic [mfs_pkg::FRAME_W-1:0]  dividend,
	output logic                         busy,
	output mfs_pkg::rem_result_t         result
);
	import mfs_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAME_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FRAME_W-1:0] dvd_q;
	logic [FRAME_W-1:0] div_q;
	logic [FRAME_W-1:0] rem_q;
	logic               done_q;
	logic [FRAME_W:0]   trial;
	logic [FRAME_W:0]   diff;
	logic [FRAME_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[FRAME_W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[FRAME_W-1:0];
		end else begin
			rem_next = trial[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FRAME_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy         = busy_q | start;
	assign result.valid = done_q;
	assign result.value = rem_q;

endmodule

FILE: rtl/core/mfs_core.sv
// Slot counters, word register and Manchester level selection.
module mfs_core #(
	parameter int unsigned WORD_BITS  = mfs_pkg::WORD_BITS_DEF,
	parameter int unsigned SYNC_SLOTS = mfs_pkg::SYNC_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [mfs_pkg::IN_WORD_W-1:0] next_word,
	input  logic [mfs_pkg::FRAME_W-1:0]   frames_per_slot,
	input  mfs_pkg::rem_result_t          residue,
	output logic [mfs_pkg::FRAME_W-1:0]   frame_count,
	output logic                          level,
	output logic                          taken
);
	import mfs_pkg::*;

	localparam int unsigned MSG_SLOTS   = 2 * WORD_BITS;
	localparam int unsigned TOTAL_SLOTS = MSG_SLOTS + SYNC_SLOTS;
	localparam int unsigned SLOT_W      = $clog2(TOTAL_SLOTS);
	localparam int unsigned POS_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	logic [FRAME_W-1:0]   frame_q;
	logic [FRAME_W-1:0]   resid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [POS_W-1:0]     pos_q;
	logic [WORD_BITS-1:0] word_q;

	logic [FRAME_W:0]     frame_inc;
	logic [FRAME_W:0]     resid_inc;
	logic                 slot_end;
	logic [SLOT_W:0]      slot_inc;
	logic                 wrap;
	logic [SLOT_W-1:0]    sync_off;
	logic [3:0]           sync_idx;

	always_comb begin
		frame_inc = {1'b0, frame_q} + 1'b1;
		resid_inc = {1'b0, resid_q} + 1'b1;
		// A slot ends on a residue match or when the frame count wraps.
		slot_end  = frame_inc[FRAME_W] || (resid_inc == {1'b0, frames_per_slot});
		slot_inc  = {1'b0, slot_q} + 1'b1;
		wrap      = slot_end && (slot_inc >= (SLOT_W+1)'(TOTAL_SLOTS));
		sync_off  = slot_q - SLOT_W'(MSG_SLOTS);
		sync_idx  = 4'(sync_off);
		if (slot_q < SLOT_W'(MSG_SLOTS)) begin
			level = (slot_q[0] == word_q[pos_q]);
		end else begin
			level = SYNC_PATTERN[sync_idx];
		end
		taken = wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			resid_q <= '0;
			slot_q  <= '0;
			pos_q   <= '0;
			word_q  <= '0;
		end else if (residue.valid) begin
			resid_q <= residue.value;
		end else if (advance) begin
			if (slot_end) begin
				frame_q <= '0;
				resid_q <= '0;
				if (wrap) begin
					slot_q <= '0;
					pos_q  <= POS_W'(WORD_BITS - 1);
					word_q <= WORD_BITS'(next_word);
				end else begin
					slot_q <= slot_inc[SLOT_W-1:0];
					if (!slot_inc[0] && (pos_q != '0)) begin
						pos_q <= pos_q - 1'b1;
					end
				end
			end else begin
				frame_q <= frame_inc[FRAME_W-1:0];
				resid_q <= resid_inc[FRAME_W-1:0];
			end
		end
	end

	assign frame_count = frame_q;

endmodule

FILE: tb/sv/mfs_line_checker.sv
`timescale 1ns / 1ps
// Watches the channels, predicts each line's level, taken and last, and checks the output.
module mfs_line_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mfs_pkg::FRAME_W-1:0]   wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mfs_pkg::IN_WORD_W-1:0] next_word,
	input  logic                          last_frame,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          line_level,
	input  logic                          word_taken,
	input  logic                          last_out,
	output int unsigned                   mismatch_count,
	output int unsigned                   lines_owed
);
	import mfs_pkg::*;

	localparam int unsigned MSG_SLOTS = 2 * WORD_BITS_DEF;
	localparam int unsigned ALL_SLOTS = MSG_SLOTS + SYNC_SLOTS_DEF;

	typedef struct packed {
		logic level;
		logic taken;
		logic last;
	} line_result_t;

	line_result_t          expected_lines[$];
	logic [FRAME_W-1:0]    slot_len  = FRAMES_PER_SLOT_RST;
	logic [FRAME_W-1:0]    frame_ctr = '0;
	logic [6:0]            slot_num  = '0;
	logic [4:0]            bit_pos   = '0;
	logic [IN_WORD_W-1:0]  word_reg  = '0;
	int unsigned           reported  = 0;

	// Advances the encoder by one frame and queues the line level it produces.
	task automatic encode_frame(input logic [IN_WORD_W-1:0] word_in, input logic last_in);
		line_result_t line;
		logic         slot_done;
		logic [3:0]   sync_idx;
		line.last  = last_in;
		line.taken = 1'b0;
		if (slot_num < MSG_SLOTS) begin
			// First half of a bit is low for a one, second half is high.
			line.level = (slot_num[0] == word_reg[bit_pos]);
		end else begin
			sync_idx = 4'(slot_num - MSG_SLOTS);
			line.level = SYNC_PATTERN[sync_idx];
		end
		frame_ctr = frame_ctr + 1'b1;
		if (slot_len == '0)
			slot_done = (frame_ctr == '0);
		else
			slot_done = ((frame_ctr % slot_len) == '0);
		if (slot_done) begin
			frame_ctr = '0;
			slot_num = slot_num + 1'b1;
			if (!slot_num[0] && bit_pos != '0)
				bit_pos = bit_pos - 1'b1;
			if (slot_num >= ALL_SLOTS) begin
				slot_num = '0;
				bit_pos = 5'(WORD_BITS_DEF - 1);
				word_reg = word_in;
				line.taken = 1'b1;
			end
		end
		expected_lines.push_back(line);
	endtask

	task automatic check_line(input line_result_t seen);
		line_result_t want;
		if (expected_lines.size() == 0) begin
			mismatch_count++;
			if (reported < 10) begin
				reported++;
				$display("%0t: unexpected line transaction: level %0b taken %0b last %0b",
					$time, seen.level, seen.taken, seen.last);
			end
		end else begin
			want = expected_lines.pop_front();
			if (seen.level !== want.level || seen.taken !== want.taken ||
					seen.last !== want.last) begin
				mismatch_count++;
				if (reported < 10) begin
					reported++;
					$display("%0t: line mismatch (level taken last): exp %0b%0b%0b got %0b%0b%0b",
						$time, want.level, want.taken, want.last,
						seen.level, seen.taken, seen.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_len = FRAMES_PER_SLOT_RST;
			frame_ctr = '0;
			slot_num = '0;
			bit_pos = '0;
			word_reg = '0;
			expected_lines.delete();
			lines_owed = 0;
		end else begin
			if (wr_en)
				slot_len = wr_data;
			// Retire before predicting so a fresh transaction never matches itself.
			if (out_valid && !out_stall)
				check_line('{line_level, word_taken, last_out});
			if (in_valid && !in_stall)
				encode_frame(next_word, last_frame);
			lines_owed = expected_lines.size();
		end
	end

endmodule

FILE: tb/sv/tb_manchester_frame_serializer.sv
`timescale 1ns / 1ps
// Testbench top for the Manchester frame serializer: clock, reset, stimulus and verdict.
module tb_manchester_frame_serializer;
	import mfs_pkg::*;

	localparam logic [IN_WORD_W-1:0] CORNER_WORDS [8] = '{
		32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
		32'haaaa_aaaa, 32'h5555_5555, 32'h0000_ffff, 32'hffff_0000
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [FRAME_W-1:0]   wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [IN_WORD_W-1:0] next_word;
	logic                 last_frame;
	logic                 out_valid;
	logic                 out_stall;
	logic                 line_level;
	logic                 word_taken;
	logic                 last_out;
	int unsigned          mismatch_count;
	int unsigned          lines_owed;
	bit                   no_idle = 1'b0;
	bit                   sink_hold_req = 1'b0;

	always #1 clk = ~clk;

	manchester_frame_serializer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.next_word  (next_word),
		.last_frame (last_frame),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_level (line_level),
		.word_taken (word_taken),
		.last_out   (last_out)
	);

	mfs_line_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.next_word      (next_word),
		.last_frame     (last_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_level     (line_level),
		.word_taken     (word_taken),
		.last_out       (last_out),
		.mismatch_count (mismatch_count),
		.lines_owed     (lines_owed)
	);

	function automatic logic [IN_WORD_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 23);
		if (r < 8)
			return CORNER_WORDS[3'(r)];
		return $urandom();
	endfunction

	// Offers one frame after an optional gap and holds it until the serializer accepts it.
	task automatic send_frame(input logic [IN_WORD_W-1:0] word_in, input logic last_in);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		next_word <= word_in;
		last_frame <= last_in;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_frames(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_frame(pick_word(), 1'($urandom_range(0, 1)));
	endtask

	task automatic drain_lines();
		in_valid <= 1'b0;
		while (lines_owed != 0) @(negedge clk);
	endtask

	task automatic set_slot_len(input logic [FRAME_W-1:0] value);
		drain_lines();
		wr_en <= 1'b1;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned stall_left;
		int unsigned run_left;
		int unsigned hold_left;
		bit          hold_used;
		stall_left = 0;
		run_left = 0;
		hold_left = 0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req && !hold_used) begin
				hold_left = 80;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (no_idle) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 8);
				stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned k;
		int unsigned sent;
		int unsigned phase_len;
		int unsigned phase_no;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		in_valid = 1'b0;
		next_word = '0;
		last_frame = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset slot length; the first period sends an all-zero word.
		for (k = 0; k < 90; k++)
			send_frame({IN_WORD_W{k[0]}}, k[0]);

		set_slot_len(16'd1);
		for (k = 0; k < 24; k++)
			send_frame(CORNER_WORDS[3'(k)], (k % 3) == 0);

		// Shorten the slot while the frame count is already well past the new length.
		set_slot_len(16'd1000);
		send_random_frames(300);
		set_slot_len(16'd7);
		send_random_frames(40);

		// Longest slot, then a zero length that behaves as 65536 frames.
		no_idle = 1'b1;
		set_slot_len(16'hffff);
		send_random_frames(100);
		set_slot_len(16'h0000);
		send_random_frames(100);
		no_idle = 1'b0;

		sent = 0;
		phase_no = 0;
		while (sent < 700) begin
			k = $urandom_range(0, 9);
			if (k < 7)
				set_slot_len(16'($urandom_range(1, 3)));
			else if (k < 9)
				set_slot_len(16'($urandom_range(4, 12)));
			else
				set_slot_len(16'($urandom_range(13, 40)));
			no_idle = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(100, 250);
			for (k = 0; k < phase_len; k++) begin
				if (phase_no == 1 && k == phase_len / 2)
					sink_hold_req = 1'b1;
				if (phase_no == 2 && k == phase_len / 2)
					drain_lines();
				send_frame(pick_word(), 1'($urandom_range(0, 1)));
			end
			sent += phase_len;
			phase_no++;
		end
		no_idle = 1'b0;

		drain_lines();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && lines_owed == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: manchester_frame_serializer.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_residue.sv
rtl/core/mfs_core.sv
rtl/core/manchester_frame_serializer.sv
tb/sv/mfs_line_checker.sv
tb/sv/tb_manchester_frame_serializer.sv
